// ===== rtl/core/seasonal_cluster_outlier_detector_defines.svh =====
// Assertion macros used by the checker file of the outlier detector.
// No dependencies; include by bare file name.
`ifndef SEASONAL_CLUSTER_OUTLIER_DETECTOR_DEFINES_SVH
`define SEASONAL_CLUSTER_OUTLIER_DETECTOR_DEFINES_SVH

// Clocked property, ignored while reset is asserted.
`define SCOD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("scod assertion failed");

// Clocked property that also holds during reset.
`define SCOD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scod assertion failed during reset or run");

`endif

// ===== rtl/core/scod_pkg.sv =====
// Shared types and constants of the seasonal cluster outlier detector.
// No dependencies.
package scod_pkg;

    localparam int SMP_W  = 16;   // Q8.8 sample width
    localparam int CHG_W  = 17;   // now minus earlier
    localparam int CTR_W  = 18;   // bucket centre
    localparam int DIST_W = 18;   // saturated distance
    localparam int THR_W  = 20;   // mean, peak, threshold
    localparam int BKT_W  = 4;
    localparam int RAD_W  = 38;   // sum of two squares
    localparam int ROOT_W = 19;

    typedef enum logic {
        ITU_DIV,
        ITU_SQRT
    } t_itu_op;

    typedef struct packed {
        logic    start;
        t_itu_op op;
    } t_itu_ctl;

    typedef enum logic {
        CMD_LEARN = 1'b0,
        CMD_CHECK = 1'b1
    } t_cmd;

endpackage

// ===== rtl/core/scod_in_if.sv =====
// Input channel of the outlier detector: one reading per beat.
// Depends on scod_pkg.
interface scod_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic [3:0]                           month;
    logic [4:0]                           hour;
    logic signed [scod_pkg::SMP_W-1:0]    temp_now;
    logic signed [scod_pkg::SMP_W-1:0]    humid_now;
    logic signed [scod_pkg::SMP_W-1:0]    temp_earlier;
    logic signed [scod_pkg::SMP_W-1:0]    humid_earlier;

    modport source (output valid, command, month, hour, temp_now, humid_now,
                    temp_earlier, humid_earlier, input ready);
    modport sink   (input valid, command, month, hour, temp_now, humid_now,
                    temp_earlier, humid_earlier, output ready);
endinterface

// ===== rtl/core/scod_out_if.sv =====
// Result channel of the outlier detector: one verdict per beat.
// Depends on scod_pkg.
interface scod_out_if;
    logic                              valid;
    logic                              ready;
    logic [scod_pkg::BKT_W-1:0]        bucket;
    logic                              is_outlier;
    logic [scod_pkg::DIST_W-1:0]       distance;
    logic [scod_pkg::THR_W-1:0]        threshold;

    modport source (output valid, bucket, is_outlier, distance, threshold,
                    input ready);
    modport sink   (input valid, bucket, is_outlier, distance, threshold,
                    output ready);
endinterface

// ===== rtl/core/scod_itu.sv =====
// Shared iterative unit: restoring divide (one quotient bit per cycle)
// or integer square root (one root bit per cycle). Depends on scod_pkg.
module scod_itu #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scod_pkg::t_itu_ctl            i_ctl,
    input  logic [COUNT_WIDTH+20:0]       i_num,
    input  logic [COUNT_WIDTH:0]          i_den,
    input  logic [scod_pkg::RAD_W-1:0]    i_rad,
    output logic                          o_done,
    output logic [COUNT_WIDTH+20:0]       o_quot,
    output logic [scod_pkg::ROOT_W-1:0]   o_root
);
    import scod_pkg::*;

    localparam int NW = COUNT_WIDTH + 21;
    localparam int AW = (NW > RAD_W) ? NW : RAD_W;
    localparam int SW = (COUNT_WIDTH + 3 > 23) ? COUNT_WIDTH + 3 : 23;
    localparam int CNT_W = $clog2(AW + 1);

    logic [AW-1:0]       r_acc;
    logic [SW-1:0]       r_rem;
    logic [COUNT_WIDTH:0] r_den;
    logic [ROOT_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    t_itu_op             r_op;

    logic [SW-1:0]       w_sh;
    logic [SW-1:0]       w_trial;
    logic [SW:0]         w_diff;
    logic                w_ge;

    always_comb begin
        unique case (r_op)
            ITU_DIV: begin
                w_sh    = {r_rem[SW-2:0], r_acc[AW-1]};
                w_trial = SW'(r_den);
            end
            ITU_SQRT: begin
                w_sh    = {r_rem[SW-3:0], r_acc[AW-1:AW-2]};
                w_trial = SW'({r_root, 2'b01});
            end
        endcase
        w_diff = {1'b0, w_sh} - {1'b0, w_trial};
        w_ge   = ~w_diff[SW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ITU_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_cnt  <= (i_ctl.op == ITU_DIV) ? CNT_W'(NW) : CNT_W'(RAD_W / 2);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_den  <= i_den;
            if (i_ctl.op == ITU_DIV) begin
                r_acc <= AW'(i_num) << (AW - NW);
            end else begin
                r_acc <= AW'(i_rad) << (AW - RAD_W);
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SW-1:0] : w_sh;
            if (r_op == ITU_DIV) begin
                r_acc <= {r_acc[AW-2:0], w_ge};
            end else begin
                r_acc  <= {r_acc[AW-3:0], 2'b00};
                r_root <= {r_root[ROOT_W-2:0], w_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc[NW-1:0];
    assign o_root = r_root;

endmodule

// ===== rtl/core/seasonal_cluster_outlier_detector.sv =====
// Seasonal cluster outlier detector: top level, sequencer and bucket store.
// Depends on scod_pkg, scod_in_if, scod_out_if and scod_itu.
//
// One reading is taken at a time; ready is high only while the block is idle,
// and a result beat is held until taken. The reading's change vector is
// compared with the centre of one of 12 season and time-of-day buckets. All
// divisions and square roots run on one shared unit at one bit per cycle,
// which sets how long a reading takes: a check runs one distance; a learn
// runs two distances and three divisions. Bucket statistics sit in
// flip-flops and are cleared at reset.
module seasonal_cluster_outlier_detector #(
    parameter int NUM_BUCKETS = 12,
    parameter int COUNT_WIDTH = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    scod_in_if.sink    i_in,
    scod_out_if.source o_out
);
    import scod_pkg::*;

    localparam int NW  = COUNT_WIDTH + 21;
    localparam int MB  = (COUNT_WIDTH > ROOT_W) ? COUNT_WIDTH : ROOT_W;
    localparam int PW  = THR_W + MB;
    localparam int BIW = $clog2(NUM_BUCKETS);

    typedef enum logic [3:0] {
        S_IDLE, S_SQT, S_SQH, S_ROOT, S_RWAIT,
        S_MMUL, S_MDIV, S_MWAIT,
        S_TMUL, S_TDIV, S_TWAIT,
        S_HMUL, S_HDIV, S_HWAIT,
        S_OUT
    } t_state;

    function automatic logic [BKT_W-1:0] f_bucket(
        input logic [3:0]       month,
        input logic [4:0]       hour,
        input logic [BKT_W-1:0] last
    );
        logic [BKT_W-1:0] base;
        logic [4:0]       early;
        logic [BKT_W-1:0] res;
        base  = '0;
        early = '0;
        res   = last;
        priority if (month == 4'd12 || month == 4'd1 || month == 4'd2) begin
            base = 4'd0; early = 5'd7;
        end else if (month >= 4'd3 && month <= 4'd5) begin
            base = 4'd3; early = 5'd6;
        end else if (month >= 4'd6 && month <= 4'd8) begin
            base = 4'd6; early = 5'd5;
        end else if (month >= 4'd9 && month <= 4'd11) begin
            base = 4'd9; early = 5'd6;
        end else begin
            base = '0; early = '0;
        end
        if (month >= 4'd1 && month <= 4'd12) begin
            priority if (hour <= early) res = base;
            else if (hour >= 5'd8 && hour <= 5'd14) res = base + 4'd1;
            else res = base + 4'd2;
        end
        if (res >= BKT_W'(NUM_BUCKETS)) res = '0;
        return res;
    endfunction

    // bucket store
    logic signed [CTR_W-1:0] r_ctr_t [NUM_BUCKETS];
    logic signed [CTR_W-1:0] r_ctr_h [NUM_BUCKETS];
    logic [THR_W-1:0]        r_mean  [NUM_BUCKETS];
    logic [THR_W-1:0]        r_peak  [NUM_BUCKETS];
    logic [THR_W-1:0]        r_thr   [NUM_BUCKETS];
    logic [COUNT_WIDTH-1:0]  r_cnt   [NUM_BUCKETS];

    t_state                  r_state;
    logic [BKT_W-1:0]        r_last;
    logic [BKT_W-1:0]        r_bkt;
    logic                    r_pass;
    logic                    r_o_outl;
    logic [DIST_W-1:0]       r_o_dist;
    logic [THR_W-1:0]        r_o_thr;

    // working copy of one bucket and of the reading
    t_cmd                    r_cmd;
    logic signed [CHG_W-1:0] r_ct;
    logic signed [CHG_W-1:0] r_ch;
    logic signed [CTR_W-1:0] r_wct;
    logic signed [CTR_W-1:0] r_wch;
    logic [THR_W-1:0]        r_wmean;
    logic [THR_W-1:0]        r_wpeak;
    logic [THR_W-1:0]        r_wthr;
    logic [COUNT_WIDTH-1:0]  r_wcnt;
    logic [PW-1:0]           r_prod;
    logic [PW-1:0]           r_sq;
    logic [DIST_W-1:0]       r_dold;
    logic                    r_neg;

    logic [BKT_W-1:0]        w_bkt;
    logic                    w_acc;
    logic signed [CTR_W:0]   w_dt;
    logic signed [CTR_W:0]   w_dh;
    logic [CTR_W:0]          w_adt;
    logic [CTR_W:0]          w_adh;
    logic [THR_W-1:0]        w_ma;
    logic [MB-1:0]           w_mb;
    logic [PW-1:0]           w_prod;
    logic signed [NW:0]      w_snum;
    logic [NW-1:0]           w_num;
    logic [COUNT_WIDTH:0]    w_den;
    logic [RAD_W-1:0]        w_rad;
    t_itu_ctl                w_ctl;
    logic                    w_done;
    logic [NW-1:0]           w_quot;
    logic [ROOT_W-1:0]       w_root;
    logic [DIST_W-1:0]       w_dist;
    logic [THR_W-1:0]        w_peak;
    logic [THR_W:0]          w_thsum;
    logic [THR_W-1:0]        w_thr;
    logic signed [CTR_W-1:0] w_qc;

    assign w_acc = i_in.valid && i_in.ready;
    assign w_bkt = f_bucket(i_in.month, i_in.hour, r_last);

    assign w_dt  = (CTR_W+1)'(r_ct) - (CTR_W+1)'(r_wct);
    assign w_dh  = (CTR_W+1)'(r_ch) - (CTR_W+1)'(r_wch);
    assign w_adt = w_dt[CTR_W] ? (CTR_W+1)'(-w_dt) : w_dt;
    assign w_adh = w_dh[CTR_W] ? (CTR_W+1)'(-w_dh) : w_dh;

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_SQT: begin
                w_ma = THR_W'(w_adt);
                w_mb = MB'(w_adt);
            end
            S_SQH: begin
                w_ma = THR_W'(w_adh);
                w_mb = MB'(w_adh);
            end
            S_MMUL: begin
                w_ma = r_wmean;
                w_mb = MB'(r_wcnt);
            end
            S_TMUL: begin
                w_ma = THR_W'(r_wct[CTR_W-1] ? -r_wct : r_wct);
                w_mb = MB'(r_wcnt);
            end
            S_HMUL: begin
                w_ma = THR_W'(r_wch[CTR_W-1] ? -r_wch : r_wch);
                w_mb = MB'(r_wcnt);
            end
            default: ;
        endcase
    end
    assign w_prod = PW'(w_ma) * PW'(w_mb);

    // numerator: r_neg holds the sign of the centre during a centre divide
    always_comb begin
        w_snum = r_neg ? -$signed({1'b0, NW'(r_prod)})
                       : $signed({1'b0, NW'(r_prod)});
        w_snum = w_snum + ((r_state == S_HDIV) ? (NW+1)'(r_ch) : (NW+1)'(r_ct));
        if (r_state == S_MDIV) begin
            w_num = NW'(r_prod) + NW'(r_dold);
        end else begin
            w_num = w_snum[NW] ? NW'(-w_snum) : w_snum[NW-1:0];
        end
    end

    assign w_den = (COUNT_WIDTH+1)'(r_wcnt) + 1'b1;
    assign w_rad = RAD_W'(r_sq) + RAD_W'(r_prod);

    always_comb begin
        w_ctl.start = 1'b0;
        w_ctl.op    = ITU_DIV;
        unique case (r_state)
            S_ROOT: begin
                w_ctl.start = 1'b1;
                w_ctl.op    = ITU_SQRT;
            end
            S_MDIV, S_TDIV, S_HDIV: w_ctl.start = 1'b1;
            default: ;
        endcase
    end

    scod_itu #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_itu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_num  (w_num),
        .i_den  (w_den),
        .i_rad  (w_rad),
        .o_done (w_done),
        .o_quot (w_quot),
        .o_root (w_root)
    );

    assign w_dist  = w_root[ROOT_W-1] ? {DIST_W{1'b1}} : w_root[DIST_W-1:0];
    assign w_peak  = (THR_W'(w_dist) > r_wpeak) ? THR_W'(w_dist) : r_wpeak;
    assign w_thsum = (THR_W+1)'(r_wmean) + (THR_W+1)'(w_peak >> 1);
    assign w_thr   = w_thsum[THR_W] ? {THR_W{1'b1}} : w_thsum[THR_W-1:0];
    assign w_qc    = r_neg ? -$signed(w_quot[CTR_W-1:0]) : $signed(w_quot[CTR_W-1:0]);

    // sequencer, bucket store and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_last   <= '0;
            r_bkt    <= '0;
            r_pass   <= 1'b0;
            r_o_outl <= 1'b0;
            r_o_dist <= '0;
            r_o_thr  <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_ctr_t[i] <= '0;
                r_ctr_h[i] <= '0;
                r_mean[i]  <= '0;
                r_peak[i]  <= '0;
                r_thr[i]   <= '0;
                r_cnt[i]   <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_last  <= w_bkt;
                        r_bkt   <= w_bkt;
                        r_pass  <= 1'b0;
                        r_state <= S_SQT;
                    end
                end
                S_SQT:  r_state <= S_SQH;
                S_SQH:  r_state <= S_ROOT;
                S_ROOT: r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (w_done) begin
                        if (!r_pass) begin
                            r_o_dist <= w_dist;
                            r_o_outl <= (r_cmd == CMD_CHECK) && (THR_W'(w_dist) > r_wthr);
                            r_o_thr  <= r_wthr;
                            r_state  <= (r_cmd == CMD_CHECK) ? S_OUT : S_MMUL;
                        end else begin
                            r_ctr_t[r_bkt[BIW-1:0]] <= r_wct;
                            r_ctr_h[r_bkt[BIW-1:0]] <= r_wch;
                            r_mean[r_bkt[BIW-1:0]]  <= r_wmean;
                            r_peak[r_bkt[BIW-1:0]]  <= w_peak;
                            r_thr[r_bkt[BIW-1:0]]   <= w_thr;
                            // hold at full scale
                            if (r_wcnt != {COUNT_WIDTH{1'b1}}) begin
                                r_cnt[r_bkt[BIW-1:0]] <= r_wcnt + 1'b1;
                            end
                            r_o_thr <= w_thr;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_MMUL: r_state <= S_MDIV;
                S_MDIV: r_state <= S_MWAIT;
                S_MWAIT: if (w_done) r_state <= S_TMUL;
                S_TMUL: r_state <= S_TDIV;
                S_TDIV: r_state <= S_TWAIT;
                S_TWAIT: if (w_done) r_state <= S_HMUL;
                S_HMUL: r_state <= S_HDIV;
                S_HDIV: r_state <= S_HWAIT;
                S_HWAIT: begin
                    if (w_done) begin
                        r_pass  <= 1'b1;
                        r_state <= S_SQT;
                    end
                end
                S_OUT: if (o_out.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_acc) begin
            r_cmd   <= t_cmd'(i_in.command);
            r_ct    <= CHG_W'(i_in.temp_now) - CHG_W'(i_in.temp_earlier);
            r_ch    <= CHG_W'(i_in.humid_now) - CHG_W'(i_in.humid_earlier);
            r_wct   <= r_ctr_t[w_bkt[BIW-1:0]];
            r_wch   <= r_ctr_h[w_bkt[BIW-1:0]];
            r_wmean <= r_mean[w_bkt[BIW-1:0]];
            r_wpeak <= r_peak[w_bkt[BIW-1:0]];
            r_wthr  <= r_thr[w_bkt[BIW-1:0]];
            r_wcnt  <= r_cnt[w_bkt[BIW-1:0]];
        end
        if (r_state == S_SQH) r_sq <= r_prod;
        if (r_state == S_RWAIT && w_done && !r_pass) r_dold <= w_dist;
        if (r_state == S_TMUL) r_neg <= r_wct[CTR_W-1];
        if (r_state == S_HMUL) r_neg <= r_wch[CTR_W-1];
        if (r_state == S_TDIV || r_state == S_HDIV) r_neg <= w_snum[NW];
        if (r_state == S_MWAIT && w_done) r_wmean <= w_quot[THR_W-1:0];
        if (r_state == S_TWAIT && w_done) r_wct <= w_qc;
        if (r_state == S_HWAIT && w_done) r_wch <= w_qc;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = (r_state == S_OUT);
    assign o_out.bucket     = r_bkt;
    assign o_out.is_outlier = r_o_outl;
    assign o_out.distance   = r_o_dist;
    assign o_out.threshold  = r_o_thr;

endmodule

// ===== rtl/core/scod_checker.sv =====
// Port-level checks of the outlier detector, bound to the top level.
// Depends on scod_pkg and seasonal_cluster_outlier_detector_defines.svh.
`include "seasonal_cluster_outlier_detector_defines.svh"

module scod_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [scod_pkg::BKT_W-1:0]   i_bucket,
    input logic                         i_is_outlier,
    input logic [scod_pkg::DIST_W-1:0]  i_distance,
    input logic [scod_pkg::THR_W-1:0]   i_threshold
);
    // a stalled result beat stays up
    `SCOD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    // busy right after taking a reading
    `SCOD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)
    // never take a reading while a result is pending
    `SCOD_ASSERT(a_no_overlap, i_clk, i_rst_n, !(i_out_valid && i_in_ready))
    // a flag means the distance was above the threshold shown
    `SCOD_ASSERT(a_flag_consistent, i_clk, i_rst_n, i_out_valid && i_is_outlier |-> 20'(i_distance) > i_threshold)
    `SCOD_ASSERT(a_bucket_range, i_clk, i_rst_n, i_out_valid |-> i_bucket < 4'd12)
endmodule

bind seasonal_cluster_outlier_detector scod_checker u_scod_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_bucket    (o_out.bucket),
    .i_is_outlier(o_out.is_outlier),
    .i_distance  (o_out.distance),
    .i_threshold (o_out.threshold)
);
